/* rtl/gad_pkg.sv */
// gad_pkg: shared types and constants for the gamepad axis deadzone block
`timescale 1ns / 1ps
package gad_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int RSP_DEPTH   = 4;

   // register indexes
   localparam logic [1:0] CSR_STICK_DZ  = 2'd0;
   localparam logic [1:0] CSR_TRIG_DZ   = 2'd1;
   localparam logic [1:0] CSR_TRIG_THR  = 2'd2;

   localparam logic [14:0] STICK_DZ_RESET = 15'd4915;
   localparam logic [14:0] TRIG_DZ_RESET  = 15'd4915;
   localparam logic [15:0] TRIG_THR_RESET = 16'd4915;
   localparam logic [16:0] FULL_SCALE     = 17'd32768;
   localparam logic [3:0]  TRIG_KEY_BASE  = 4'd6;

   typedef struct packed {
      logic [14:0] stick_dz;
      logic [14:0] trig_dz;
      logic [15:0] trig_thr;
   } cfg_type;

   // classified word handed from front to back
   typedef struct packed {
      logic [1:0]  cmd;
      logic        trig;
      logic        x_neg;
      logic        y_neg;
      logic [15:0] ax;
      logic [15:0] ay;
   } item_type;

   typedef struct packed {
      logic [3:0]  key;
      logic        pressed;
      logic [15:0] amount;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_SQRT,
      ST_CHECK,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_SCALE,
      OP_COMP_X,
      OP_COMP_Y,
      OP_TRIG
   } div_op_type;

endpackage

/* rtl/gad_front.sv */
// gad_front: accepts samples, brings them to q.15, classifies and queues them
`timescale 1ns / 1ps
module gad_front #(
   parameter int SAMPLE_BITS = gad_pkg::SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_cmd,
   input  logic signed [SAMPLE_BITS-1:0] req_x_pos,
   input  logic signed [SAMPLE_BITS-1:0] req_y_pos,
   output logic                          q_valid,
   input  logic                          q_pop,
   output gad_pkg::item_type             q_item
);
   localparam int PW = $clog2(gad_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(gad_pkg::QUEUE_DEPTH + 1);

   logic signed [15:0] x_q15;
   logic signed [15:0] y_q15;
   gad_pkg::item_type  cls;

   gad_pkg::item_type  mem_ff [gad_pkg::QUEUE_DEPTH];
   logic [PW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               do_push, do_pop;

   // sample to q.15 by arithmetic shift
   generate
      if (SAMPLE_BITS >= 16) begin : g_down
         assign x_q15 = req_x_pos[SAMPLE_BITS-1 -: 16];
         assign y_q15 = req_y_pos[SAMPLE_BITS-1 -: 16];
      end else begin : g_up
         assign x_q15 = {req_x_pos, {(16-SAMPLE_BITS){1'b0}}};
         assign y_q15 = {req_y_pos, {(16-SAMPLE_BITS){1'b0}}};
      end
   endgenerate

   // sign and magnitude split
   always_comb begin
      cls.cmd   = req_cmd;
      cls.trig  = req_cmd[1];
      cls.x_neg = x_q15[15];
      cls.y_neg = y_q15[15];
      cls.ax    = x_q15[15] ? 16'(-x_q15) : x_q15;
      cls.ay    = y_q15[15] ? 16'(-y_q15) : y_q15;
   end

   assign req_full = (cnt_ff == CW'(gad_pkg::QUEUE_DEPTH));
   assign q_valid  = (cnt_ff != '0);
   assign q_item   = mem_ff[rd_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && q_valid;

   // queue pointers
   always_comb begin
      wr_in  = do_push ? PW'((32'(wr_ff) + 1) % gad_pkg::QUEUE_DEPTH) : wr_ff;
      rd_in  = do_pop  ? PW'((32'(rd_ff) + 1) % gad_pkg::QUEUE_DEPTH) : rd_ff;
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= cls;
      end
   end
endmodule

/* rtl/gad_div.sv */
// gad_div: restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module gad_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] dq_ff, dq_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] dvs_ff;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [17:0] rem_sh;
   logic        ge;

   // one shift and subtract step
   always_comb begin
      rem_sh  = {rem_ff, dq_ff[31]};
      ge      = (rem_sh >= {1'b0, dvs_ff});
      rem_in  = ge ? 17'(rem_sh - {1'b0, dvs_ff}) : rem_sh[16:0];
      dq_in   = {dq_ff[30:0], ge};
      cnt_in  = cnt_ff + 5'd1;
      busy_in = busy_ff && (cnt_ff != 5'd31);
      done_in = busy_ff && (cnt_ff == 5'd31);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= busy_ff ? cnt_in : cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff;
endmodule

/* rtl/gad_back.sv */
// gad_back: magnitude, rescale and key event sequencer with result queue
`timescale 1ns / 1ps
module gad_back (
   input  logic              clock,
   input  logic              reset,
   input  gad_pkg::cfg_type  cfg,
   input  logic              q_valid,
   output logic              q_pop,
   input  gad_pkg::item_type q_item,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [3:0]        rsp_key,
   output logic              rsp_pressed,
   output logic [15:0]       rsp_amount,
   output logic              rsp_last
);
   localparam int PW = $clog2(gad_pkg::RSP_DEPTH);
   localparam int CW = $clog2(gad_pkg::RSP_DEPTH + 1);

   gad_pkg::state_type  state_ff, state_in;
   gad_pkg::div_op_type op_ff;
   gad_pkg::item_type   item_ff;
   logic [31:0] sq_x_ff, sq_y_ff, rad_ff;
   logic [17:0] rem_ff;
   logic [15:0] root_ff;
   logic [3:0]  cnt_ff;
   logic [16:0] scale_ff, vx_ff, vy_ff;
   logic [1:0]  emit_ff;

   logic [19:0] rem_sh, trial;
   logic        sq_ge;
   logic        stick_idle, trig_go, emit_done;
   logic        div_start, div_done;
   logic [31:0] div_dvd, div_q;
   logic [16:0] div_dvs, scale_clamp;
   logic [32:0] prod;
   logic [16:0] v;
   logic        neg;

   gad_pkg::rsp_type rsp_mem_ff [gad_pkg::RSP_DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [CW-1:0]    rcnt_ff;
   logic             rsp_full, push, do_pop;
   gad_pkg::rsp_type push_word;

   // sqrt step and decisions
   always_comb begin
      rem_sh      = {rem_ff, rad_ff[31:30]};
      trial       = {2'b00, root_ff, 2'b01};
      sq_ge       = (rem_sh >= trial);
      stick_idle  = (root_ff == '0) || (root_ff < {1'b0, cfg.stick_dz});
      trig_go     = !q_item.x_neg && (q_item.ax >= {1'b0, cfg.trig_dz});
      emit_done   = item_ff.trig || (emit_ff == 2'd3);
      scale_clamp = (div_q > 32'(gad_pkg::FULL_SCALE)) ? gad_pkg::FULL_SCALE : div_q[16:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gad_pkg::ST_IDLE: begin
            if (q_valid) begin
               if (!q_item.trig) state_in = gad_pkg::ST_SQUARE;
               else if (trig_go) state_in = gad_pkg::ST_DIV_GO;
               else              state_in = gad_pkg::ST_EMIT;
            end
         end
         gad_pkg::ST_SQUARE: state_in = gad_pkg::ST_SUM;
         gad_pkg::ST_SUM:    state_in = gad_pkg::ST_SQRT;
         gad_pkg::ST_SQRT: begin
            if (cnt_ff == 4'd15) state_in = gad_pkg::ST_CHECK;
         end
         gad_pkg::ST_CHECK: begin
            state_in = stick_idle ? gad_pkg::ST_EMIT : gad_pkg::ST_DIV_GO;
         end
         gad_pkg::ST_DIV_GO: state_in = gad_pkg::ST_DIV_WAIT;
         gad_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               if (op_ff == gad_pkg::OP_COMP_Y || op_ff == gad_pkg::OP_TRIG)
                  state_in = gad_pkg::ST_EMIT;
               else
                  state_in = gad_pkg::ST_DIV_GO;
            end
         end
         gad_pkg::ST_EMIT: begin
            if (!rsp_full && emit_done) state_in = gad_pkg::ST_IDLE;
         end
         default: state_in = gad_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      push      = 1'b0;
      div_dvd   = '0;
      div_dvs   = 17'd1;
      prod      = '0;
      case (state_ff)
         gad_pkg::ST_IDLE:   q_pop = q_valid;
         gad_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            case (op_ff)
               gad_pkg::OP_SCALE: begin
                  div_dvd = {17'(root_ff - {1'b0, cfg.stick_dz}), 15'd0};
                  div_dvs = gad_pkg::FULL_SCALE - {2'b00, cfg.stick_dz};
               end
               gad_pkg::OP_COMP_X: begin
                  prod    = item_ff.ax * scale_ff;
                  div_dvd = prod[31:0];
                  div_dvs = {1'b0, root_ff};
               end
               gad_pkg::OP_COMP_Y: begin
                  prod    = item_ff.ay * scale_ff;
                  div_dvd = prod[31:0];
                  div_dvs = {1'b0, root_ff};
               end
               gad_pkg::OP_TRIG: begin
                  div_dvd = {17'(item_ff.ax - {1'b0, cfg.trig_dz}), 15'd0};
                  div_dvs = gad_pkg::FULL_SCALE - {2'b00, cfg.trig_dz};
               end
               default: div_dvd = '0;
            endcase
         end
         gad_pkg::ST_EMIT:   push = !rsp_full;
         default:            q_pop = 1'b0;
      endcase
   end

   // event word for the current emit step
   always_comb begin
      v   = emit_ff[1] ? vy_ff : vx_ff;
      neg = emit_ff[1] ? item_ff.y_neg : item_ff.x_neg;
      if (item_ff.trig) begin
         push_word.key     = gad_pkg::TRIG_KEY_BASE + {2'b00, item_ff.cmd};
         push_word.amount  = vx_ff[15:0];
         push_word.pressed = ({1'b0, vx_ff[15:0]} > {1'b0, cfg.trig_thr});
         push_word.last    = 1'b1;
      end else begin
         push_word.key     = {1'b0, item_ff.cmd[0], emit_ff};
         push_word.pressed = (v != '0) && (emit_ff[0] ? !neg : neg);
         push_word.amount  = push_word.pressed ? v[15:0] : 16'd0;
         push_word.last    = (emit_ff == 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= gad_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         gad_pkg::ST_IDLE: begin
            item_ff <= q_item;
            emit_ff <= '0;
            vx_ff   <= '0;
            vy_ff   <= '0;
            op_ff   <= q_item.trig ? gad_pkg::OP_TRIG : gad_pkg::OP_SCALE;
         end
         gad_pkg::ST_SQUARE: begin
            sq_x_ff <= item_ff.ax * item_ff.ax;
            sq_y_ff <= item_ff.ay * item_ff.ay;
         end
         gad_pkg::ST_SUM: begin
            rad_ff  <= sq_x_ff + sq_y_ff;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end
         gad_pkg::ST_SQRT: begin
            rad_ff  <= {rad_ff[29:0], 2'b00};
            rem_ff  <= sq_ge ? 18'(rem_sh - trial) : rem_sh[17:0];
            root_ff <= {root_ff[14:0], sq_ge};
            cnt_ff  <= cnt_ff + 4'd1;
         end
         gad_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               case (op_ff)
                  gad_pkg::OP_SCALE: begin
                     scale_ff <= scale_clamp;
                     op_ff    <= gad_pkg::OP_COMP_X;
                  end
                  gad_pkg::OP_COMP_X: begin
                     vx_ff <= div_q[16:0];
                     op_ff <= gad_pkg::OP_COMP_Y;
                  end
                  gad_pkg::OP_COMP_Y: vy_ff <= div_q[16:0];
                  default:            vx_ff <= div_q[16:0];
               endcase
            end
         end
         gad_pkg::ST_EMIT: begin
            if (!rsp_full) emit_ff <= emit_ff + 2'd1;
         end
         default: cnt_ff <= cnt_ff;
      endcase
   end

   gad_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   // result queue
   assign rsp_full    = (rcnt_ff == CW'(gad_pkg::RSP_DEPTH));
   assign rsp_empty   = (rcnt_ff == '0);
   assign do_pop      = rsp_pop && !rsp_empty;
   assign rsp_key     = rsp_mem_ff[rd_ff].key;
   assign rsp_pressed = rsp_mem_ff[rd_ff].pressed;
   assign rsp_amount  = rsp_mem_ff[rd_ff].amount;
   assign rsp_last    = rsp_mem_ff[rd_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         rcnt_ff <= '0;
      end else begin
         if (push)   wr_ff <= PW'((32'(wr_ff) + 1) % gad_pkg::RSP_DEPTH);
         if (do_pop) rd_ff <= PW'((32'(rd_ff) + 1) % gad_pkg::RSP_DEPTH);
         rcnt_ff <= rcnt_ff + CW'(push) - CW'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) rsp_mem_ff[wr_ff] <= push_word;
   end
endmodule

/* rtl/gamepad_axis_deadzone.sv */
// gamepad_axis_deadzone: top level with control registers, front and back
//
//  channel  ports                                  word
//  req      req_push / req_full                    cmd, x_pos, y_pos
//  rsp      rsp_pop / rsp_empty                    key, pressed, amount, last
//  csr      csr_we, csr_index, csr_wdata           register write, no wait
//
// in the back end a stick word is taken, squared and summed, then goes
// through the square root, the deadzone check, three divisions on the
// shared divider and four pushes, with no divisions inside the deadzone.
// a trigger word gets one division, none if negative or under the deadzone.
// reset is synchronous; queues empty and registers return to their defaults.
// the front queue accepts words while the back works; the back stalls only
// while the result queue is full.
`timescale 1ns / 1ps
module gamepad_axis_deadzone #(
   parameter int SAMPLE_BITS = gad_pkg::SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_cmd,
   input  logic signed [SAMPLE_BITS-1:0] req_x_pos,
   input  logic signed [SAMPLE_BITS-1:0] req_y_pos,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [3:0]                    rsp_key,
   output logic                          rsp_pressed,
   output logic [15:0]                   rsp_amount,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [15:0]                   csr_wdata
);
   gad_pkg::cfg_type  cfg_ff;
   gad_pkg::item_type q_item;
   logic              q_valid, q_pop;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stick_dz <= gad_pkg::STICK_DZ_RESET;
         cfg_ff.trig_dz  <= gad_pkg::TRIG_DZ_RESET;
         cfg_ff.trig_thr <= gad_pkg::TRIG_THR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            gad_pkg::CSR_STICK_DZ: cfg_ff.stick_dz <= csr_wdata[14:0];
            gad_pkg::CSR_TRIG_DZ:  cfg_ff.trig_dz  <= csr_wdata[14:0];
            gad_pkg::CSR_TRIG_THR: cfg_ff.trig_thr <= csr_wdata;
            default:               cfg_ff          <= cfg_ff;
         endcase
      end
   end

   gad_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_cmd   (req_cmd),
      .req_x_pos (req_x_pos),
      .req_y_pos (req_y_pos),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item)
   );

   gad_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_item      (q_item),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_key     (rsp_key),
      .rsp_pressed (rsp_pressed),
      .rsp_amount  (rsp_amount),
      .rsp_last    (rsp_last)
   );
endmodule

/* test/tb.sv */
// tb: self-checking testbench for the gamepad axis deadzone block
`timescale 1ns / 1ps

// holds the expected key events and compares accepted result words
class key_event_board;
   logic [3:0]  exp_key[$];
   logic        exp_pressed[$];
   logic [15:0] exp_amount[$];
   logic        exp_last[$];
   int          mismatches;
   logic [14:0] stick_dz;
   logic [14:0] trig_dz;
   logic [15:0] trig_thr;

   function new();
      mismatches = 0;
      stick_dz   = gad_pkg::STICK_DZ_RESET;
      trig_dz    = gad_pkg::TRIG_DZ_RESET;
      trig_thr   = gad_pkg::TRIG_THR_RESET;
   endfunction

   function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
         gad_pkg::CSR_STICK_DZ: stick_dz = val[14:0];
         gad_pkg::CSR_TRIG_DZ:  trig_dz  = val[14:0];
         gad_pkg::CSR_TRIG_THR: trig_thr = val;
         default: ;
      endcase
   endfunction

   function void push_event(logic [3:0] k, logic p, logic [15:0] a, logic l);
      exp_key.push_back(k);
      exp_pressed.push_back(p);
      exp_amount.push_back(a);
      exp_last.push_back(l);
   endfunction

   // integer square root, floor
   function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 32;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // rescale a value above the deadzone to full scale
   function longint unsigned stretch(longint unsigned v, longint unsigned dz);
      return ((v - dz) * 32768) / (32768 - dz);
   endfunction

   // note an accepted input word and predict its key events
   function void note_sample(logic [1:0] cmd, logic signed [15:0] xs,
                             logic signed [15:0] ys);
      longint x, y, ax, ay, m, sc, cx, cy, amt;
      x = xs;
      y = ys;
      if (cmd >= 2) begin
         amt = 0;
         if (x >= 0 && x >= stick_dz_dummy(trig_dz)) amt = stretch(x, trig_dz);
         push_event(4'(6 + cmd), amt > trig_thr, 16'(amt), 1'b1);
         return;
      end
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      m  = root_floor(ax * ax + ay * ay);
      cx = 0;
      cy = 0;
      if (m != 0 && m >= stick_dz) begin
         sc = stretch(m, stick_dz);
         if (sc > 32768) sc = 32768;
         cx = (ax * sc) / m;
         cy = (ay * sc) / m;
         if (x < 0) cx = -cx;
         if (y < 0) cy = -cy;
      end
      push_event(4'(cmd * 4),     cx < 0, 16'(cx < 0 ? -cx : 0), 1'b0);
      push_event(4'(cmd * 4 + 1), cx > 0, 16'(cx > 0 ? cx : 0), 1'b0);
      push_event(4'(cmd * 4 + 2), cy < 0, 16'(cy < 0 ? -cy : 0), 1'b0);
      push_event(4'(cmd * 4 + 3), cy > 0, 16'(cy > 0 ? cy : 0), 1'b1);
   endfunction

   function longint stick_dz_dummy(logic [14:0] dz);
      return dz;
   endfunction

   // compare one accepted result word with the oldest expectation
   function void check_word(logic [3:0] k, logic p, logic [15:0] a, logic l);
      if (exp_key.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected word key=%0d pressed=%0d amount=%0d last=%0d",
                     k, p, a, l);
         return;
      end
      if (k !== exp_key[0] || p !== exp_pressed[0] || a !== exp_amount[0]
          || l !== exp_last[0]) begin
         mismatches++;
         if (mismatches <= 10)
            $display("word differs: exp key=%0d pr=%0d amt=%0d last=%0d, got %0d %0d %0d %0d",
                     exp_key[0], exp_pressed[0], exp_amount[0], exp_last[0],
                     k, p, a, l);
      end
      void'(exp_key.pop_front());
      void'(exp_pressed.pop_front());
      void'(exp_amount.pop_front());
      void'(exp_last.pop_front());
   endfunction

   function int waiting();
      return exp_key.size();
   endfunction
endclass

module tb;
   localparam longint CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [1:0]         req_cmd = '0;
   logic signed [15:0] req_x_pos = '0;
   logic signed [15:0] req_y_pos = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [3:0]         rsp_key;
   logic               rsp_pressed;
   logic [15:0]        rsp_amount;
   logic               rsp_last;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   key_event_board board = new();
   longint         cycles = 0;
   bit             hold_off = 1'b0;

   gamepad_axis_deadzone dut (.*);

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // cycle count and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("gamepad_axis_deadzone: mismatch");
         $finish;
      end
   end

   // result side: random pop gaps, long hold-off on request
   initial begin : drain
      int gap;
      forever begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
         if (gap > 0 || hold_off) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         board.check_word(rsp_key, rsp_pressed, rsp_amount, rsp_last);
      end
   end

   // offer one sample word and wait for acceptance
   task automatic send_sample(logic [1:0] cmd, logic [15:0] x, logic [15:0] y,
                              bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push  <= 1'b1;
      req_cmd   <= cmd;
      req_x_pos <= x;
      req_y_pos <= y;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_sample(cmd, x, y);
   endtask

   // wait until every expected word is back, then let the back end settle
   task automatic settle();
      req_push <= 1'b0;
      while (board.waiting() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic random_phase(int n);
      logic [1:0]  c;
      logic [15:0] x, y;
      for (int i = 0; i < n; i++) begin
         c = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0: x = 16'($urandom_range(0, 600)) - 16'd300;
            1: x = 16'h8000;
            2: x = 16'h7fff;
            default: x = 16'($urandom);
         endcase
         y = $urandom_range(0, 4) == 0 ? 16'($urandom_range(0, 40)) : 16'($urandom);
         send_sample(c, x, y, $urandom_range(0, 4) != 0);
      end
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, both sticks and triggers, special cases
      send_sample(2'd0, 16'h0000, 16'h0000, 0);
      send_sample(2'd0, 16'h8000, 16'h8000, 0);
      send_sample(2'd1, 16'h7fff, 16'h7fff, 0);
      send_sample(2'd0, 16'h8000, 16'h0000, 0);
      send_sample(2'd1, 16'h0000, 16'h7fff, 0);
      send_sample(2'd0, 16'd100, 16'hff00, 0);
      send_sample(2'd1, 16'h7fff, 16'd1, 0);
      send_sample(2'd0, 16'd3000, 16'hf000, 0);
      send_sample(2'd2, 16'h8000, 16'h1234, 0);
      send_sample(2'd3, 16'h7fff, 16'h0000, 0);
      send_sample(2'd2, 16'd4915, 16'h0000, 0);
      send_sample(2'd3, 16'd9000, 16'hffff, 0);
      send_sample(2'd2, 16'hffff, 16'h0000, 0);
      settle();

      // zero deadzones, threshold at full scale
      write_reg(gad_pkg::CSR_STICK_DZ, 16'd0);
      write_reg(gad_pkg::CSR_TRIG_DZ, 16'd0);
      write_reg(gad_pkg::CSR_TRIG_THR, 16'd32768);
      write_reg(2'd3, 16'hffff);
      send_sample(2'd0, 16'h0000, 16'h0000, 0);
      send_sample(2'd1, 16'd1, 16'hffff, 0);
      send_sample(2'd3, 16'h7fff, 16'h0000, 0);
      send_sample(2'd2, 16'd0, 16'h0000, 0);
      random_phase(60);
      settle();

      // largest deadzones, threshold zero and above full
      write_reg(gad_pkg::CSR_STICK_DZ, 16'h7fff);
      write_reg(gad_pkg::CSR_TRIG_DZ, 16'hffff);
      write_reg(gad_pkg::CSR_TRIG_THR, 16'd0);
      send_sample(2'd0, 16'h8000, 16'h8000, 0);
      send_sample(2'd2, 16'h7fff, 16'h0000, 0);
      random_phase(40);
      settle();
      write_reg(gad_pkg::CSR_TRIG_THR, 16'hffff);
      random_phase(30);
      settle();

      // back-pressure: hold the result side while words keep coming
      write_reg(gad_pkg::CSR_STICK_DZ, 16'($urandom_range(0, 32767)));
      write_reg(gad_pkg::CSR_TRIG_DZ, 16'($urandom_range(0, 32767)));
      write_reg(gad_pkg::CSR_TRIG_THR, 16'($urandom_range(0, 32768)));
      hold_off = 1'b1;
      fork
         begin
            repeat (1500) @(posedge clock);
            hold_off = 1'b0;
         end
         random_phase(20);
      join
      random_phase(80);
      settle();

      // mid-range settings
      write_reg(gad_pkg::CSR_STICK_DZ, 16'd8000);
      write_reg(gad_pkg::CSR_TRIG_DZ, 16'd2000);
      write_reg(gad_pkg::CSR_TRIG_THR, 16'd16384);
      random_phase(110);
      settle();

      if (board.mismatches == 0) begin
         $display("gamepad_axis_deadzone: match");
      end else begin
         $display("gamepad_axis_deadzone: mismatch");
      end
      $finish;
   end
endmodule
